### hdl/plom_pkg.sv
// Shared types and constants for the price level order matcher.
package plom_pkg;

    localparam int PRICE_W = 24;
    localparam int LQTY_W  = 24;
    localparam int QTY_W   = 16;
    localparam int RATE_W  = 20;
    localparam int COST_W  = 36;
    localparam int SLIP_W  = 25;
    localparam logic [LQTY_W-1:0] LQTY_MAX = {LQTY_W{1'b1}};

    // One price level as held in a cell
    typedef struct packed {
        logic              used;
        logic [PRICE_W-1:0] price;
        logic [LQTY_W-1:0]  qty;
    } level_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_DEC,
        CMD_POP
    } cmd_op_t;

    // Command broadcast along a chain
    typedef struct packed {
        cmd_op_t            op;
        logic               merge;
        logic [PRICE_W-1:0] price;
        logic [LQTY_W-1:0]  qty;
    } cmd_t;

    // Summary a chain reports to the sequencer
    typedef struct packed {
        level_t front;
        logic   hit;
        logic   full;
    } chain_stat_t;

endpackage

### hdl/price_level_order_matcher_unit.sv
// Top level of the price level order matcher: sequencer, output register, two book sides.
//
//  channel  | signals                         | direction
//  ---------+---------------------------------+----------
//  in       | in_valid, in_stall, fields      | item in
//  out      | out_valid, out_stall, fields    | item out
//  config   | gas_rate_wr_en, gas_rate_wr_data| write only
//
// A non-zero add passes through ST_ADD and ST_FINAL; a zero-quantity add goes to ST_FINAL.
// A submit fills in ST_MATCH, one fill per cycle while the output register is free (the
// front cell pops or decrements), passes through ST_ADD when a remainder is left, and ends in ST_FINAL.
// One item is in work at a time; the input stalls until its completion is registered.
// A stalled output holds the sequencer until the output register frees.
// Reset clears the used bits of every level and sets gas_rate to 1000.
module price_level_order_matcher_unit #(
    parameter int LEVELS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           gas_rate_wr_en,
    input  logic [plom_pkg::RATE_W-1:0]    gas_rate_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic                           side,
    input  logic [plom_pkg::PRICE_W-1:0]   price,
    input  logic [plom_pkg::QTY_W-1:0]     quantity,
    input  logic [plom_pkg::QTY_W-1:0]     ticket,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           kind,
    output logic [plom_pkg::QTY_W-1:0]     result_ticket,
    output logic [plom_pkg::PRICE_W-1:0]   match_price,
    output logic [plom_pkg::QTY_W-1:0]     match_qty,
    output logic [plom_pkg::COST_W-1:0]    cost,
    output logic signed [plom_pkg::SLIP_W-1:0] slippage,
    output logic [plom_pkg::QTY_W-1:0]     rested_qty,
    output logic                           status,
    output logic [plom_pkg::PRICE_W-1:0]   best_bid,
    output logic [plom_pkg::PRICE_W-1:0]   best_ask,
    output logic                           last
);
    import plom_pkg::*;

    localparam int NW = $clog2(LEVELS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_ADD,
        ST_FINAL
    } state_t;

    state_t             state_reg;
    logic [RATE_W-1:0]  gas_rate_reg;
    logic               side_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]   rem_reg;
    logic [QTY_W-1:0]   oid_reg;
    logic [NW-1:0]      nfill_reg;
    logic               status_reg;
    logic [QTY_W-1:0]   rested_reg;

    chain_stat_t bid_stat, ask_stat, opp_stat, own_stat;
    cmd_t        bid_cmd, ask_cmd, opp_cmd, own_cmd;
    logic        out_free, crosses, can_fill, pop, drop, emit;
    logic [QTY_W-1:0] fq;

    assign out_free = !out_valid || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // Side selection
    assign opp_stat = side_reg ? ask_stat : bid_stat;
    assign own_stat = side_reg ? bid_stat : ask_stat;

    // Front level test and fill size
    always_comb
    begin
        if (side_reg)
            crosses = !(opp_stat.front.price > price_reg);
        else
            crosses = !(opp_stat.front.price < price_reg);
        can_fill = (rem_reg != '0) && (nfill_reg < NW'(LEVELS)) &&
                   opp_stat.front.used && crosses;
        pop = ({8'b0, rem_reg} >= opp_stat.front.qty);
        fq  = pop ? opp_stat.front.qty[QTY_W-1:0] : rem_reg;
        drop = !own_stat.hit && own_stat.full;
        emit = out_free && ((state_reg == ST_MATCH && can_fill) || state_reg == ST_FINAL);
    end

    // Chain commands
    always_comb
    begin
        opp_cmd = '{op: CMD_NONE, merge: 1'b0, price: price_reg, qty: {8'b0, fq}};
        own_cmd = '{op: CMD_NONE, merge: own_stat.hit, price: price_reg,
                    qty: {8'b0, rem_reg}};
        if (state_reg == ST_MATCH && can_fill && out_free)
            opp_cmd.op = pop ? CMD_POP : CMD_DEC;
        if (state_reg == ST_ADD && !drop)
            own_cmd.op = CMD_INSERT;
        bid_cmd = side_reg ? own_cmd : opp_cmd;
        ask_cmd = side_reg ? opp_cmd : own_cmd;
    end

    plom_chain #(.LEVELS(LEVELS), .IS_BID(1'b1)) u_bid (
        .clk (clk), .rst_n (rst_n), .cmd (bid_cmd), .stat (bid_stat)
    );

    plom_chain #(.LEVELS(LEVELS), .IS_BID(1'b0)) u_ask (
        .clk (clk), .rst_n (rst_n), .cmd (ask_cmd), .stat (ask_stat)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gas_rate_reg <= RATE_W'(1000);
        else if (gas_rate_wr_en)
            gas_rate_reg <= gas_rate_wr_data;
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            if (emit)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        side_reg   <= side;
                        price_reg  <= price;
                        rem_reg    <= quantity;
                        oid_reg    <= ticket;
                        nfill_reg  <= '0;
                        status_reg <= 1'b0;
                        rested_reg <= '0;
                        if (operation)
                            state_reg <= ST_MATCH;
                        else if (quantity != '0)
                            state_reg <= ST_ADD;
                        else
                            state_reg <= ST_FINAL;
                    end
                end
                ST_MATCH:
                begin
                    if (can_fill)
                    begin
                        if (out_free)
                        begin
                            kind          <= 1'b0;
                            result_ticket <= oid_reg;
                            match_price   <= opp_stat.front.price;
                            match_qty     <= fq;
                            cost          <= COST_W'(gas_rate_reg) * COST_W'(fq);
                            slippage      <= side_reg ?
                                ({1'b0, opp_stat.front.price} - {1'b0, price_reg}) :
                                ({1'b0, price_reg} - {1'b0, opp_stat.front.price});
                            rested_qty    <= '0;
                            status        <= 1'b0;
                            best_bid      <= '0;
                            best_ask      <= '0;
                            last          <= 1'b0;
                            rem_reg       <= rem_reg - fq;
                            nfill_reg     <= nfill_reg + NW'(1);
                        end
                    end
                    else if (rem_reg != '0)
                        state_reg <= ST_ADD;
                    else
                        state_reg <= ST_FINAL;
                end
                ST_ADD:
                begin
                    status_reg <= drop;
                    rested_reg <= drop ? '0 : rem_reg;
                    state_reg  <= ST_FINAL;
                end
                ST_FINAL:
                begin
                    if (out_free)
                    begin
                        kind          <= 1'b1;
                        result_ticket <= oid_reg;
                        match_price   <= '0;
                        match_qty     <= '0;
                        cost          <= '0;
                        slippage      <= '0;
                        rested_qty    <= rested_reg;
                        status        <= status_reg;
                        best_bid      <= bid_stat.front.used ? bid_stat.front.price : '0;
                        best_ask      <= ask_stat.front.used ? ask_stat.front.price : '0;
                        last          <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### hdl/plom_cell.sv
// One price level cell of a sorted book side.
module plom_cell #(
    parameter bit IS_BID = 1'b1,
    parameter bit HEAD   = 1'b0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  plom_pkg::cmd_t    cmd,
    input  plom_pkg::level_t  left_lvl,
    input  plom_pkg::level_t  right_lvl,
    input  logic              left_keep,
    output plom_pkg::level_t  lvl,
    output logic              keep,
    output logic              hit
);
    import plom_pkg::*;

    logic              used_reg, used_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic [LQTY_W-1:0]  qty_reg, qty_next;
    logic [LQTY_W:0]    sum;

    // Level keeps its place when it ranks ahead of the incoming price
    always_comb
    begin
        if (IS_BID)
            keep = used_reg && (price_reg > cmd.price);
        else
            keep = used_reg && (price_reg < cmd.price);
    end

    assign hit = used_reg && (price_reg == cmd.price);
    assign sum = {1'b0, qty_reg} + {1'b0, cmd.qty};
    assign lvl = '{used: used_reg, price: price_reg, qty: qty_reg};

    // Next level contents
    always_comb
    begin
        used_next  = used_reg;
        price_next = price_reg;
        qty_next   = qty_reg;
        case (cmd.op)
            CMD_INSERT:
            begin
                if (cmd.merge)
                begin
                    if (hit)
                        qty_next = sum[LQTY_W] ? LQTY_MAX : sum[LQTY_W-1:0];
                end
                else if (!keep)
                begin
                    if (left_keep)
                    begin
                        used_next  = 1'b1;
                        price_next = cmd.price;
                        qty_next   = cmd.qty;
                    end
                    else
                    begin
                        used_next  = left_lvl.used;
                        price_next = left_lvl.price;
                        qty_next   = left_lvl.qty;
                    end
                end
            end
            CMD_DEC:
            begin
                if (HEAD)
                    qty_next = qty_reg - cmd.qty;
            end
            CMD_POP:
            begin
                used_next  = right_lvl.used;
                price_next = right_lvl.price;
                qty_next   = right_lvl.qty;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= 1'b0;
        else
            used_reg <= used_next;
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        qty_reg   <= qty_next;
    end

endmodule

### hdl/plom_chain.sv
// Row of level cells forming one sorted side of the book.
module plom_chain #(
    parameter int LEVELS = 16,
    parameter bit IS_BID = 1'b1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  plom_pkg::cmd_t        cmd,
    output plom_pkg::chain_stat_t stat
);
    import plom_pkg::*;

    level_t            lvl [LEVELS];
    logic [LEVELS-1:0] keep;
    logic [LEVELS-1:0] hit;

    for (genvar i = 0; i < LEVELS; i++)
    begin : g_cell
        level_t left_lvl;
        level_t right_lvl;
        logic   left_keep;
        if (i == 0)
        begin : g_head
            assign left_lvl  = '0;
            assign left_keep = 1'b1;
        end
        else
        begin : g_body
            assign left_lvl  = lvl[i-1];
            assign left_keep = keep[i-1];
        end
        if (i == LEVELS - 1)
        begin : g_tail
            assign right_lvl = '0;
        end
        else
        begin : g_mid
            assign right_lvl = lvl[i+1];
        end
        plom_cell #(.IS_BID(IS_BID), .HEAD(i == 0)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left_lvl  (left_lvl),
            .right_lvl (right_lvl),
            .left_keep (left_keep),
            .lvl       (lvl[i]),
            .keep      (keep[i]),
            .hit       (hit[i])
        );
    end

    assign stat.front = lvl[0];
    assign stat.hit   = |hit;
    assign stat.full  = lvl[LEVELS-1].used;

endmodule
